// ===== hw/rtl/tmcs_pkg.sv =====
// types and constants shared by the motion command sequencer modules
// no dependencies

package tmcs_pkg;

   // request op codes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;

   // configuration register indexes
   localparam logic [2:0] CSR_BASE_SPEED  = 3'd0;
   localparam logic [2:0] CSR_LEFT_TRIM   = 3'd1;
   localparam logic [2:0] CSR_RIGHT_TRIM  = 3'd2;
   localparam logic [2:0] CSR_WALK_TICKS  = 3'd3;
   localparam logic [2:0] CSR_TURN_TICKS  = 3'd4;

   // motor directions
   localparam logic [1:0] DIR_STOP = 2'd0;
   localparam logic [1:0] DIR_FWD  = 2'd1;
   localparam logic [1:0] DIR_BWD  = 2'd2;

   // command letters
   localparam logic [7:0] CHAR_F = 8'h46;
   localparam logic [7:0] CHAR_B = 8'h42;
   localparam logic [7:0] CHAR_L = 8'h4C;
   localparam logic [7:0] CHAR_R = 8'h52;
   localparam logic [7:0] CHAR_S = 8'h53;

   // program store entries that can be addressed by a write request
   localparam int ENTRY_SPAN = 16;

   typedef enum logic [1:0] {
      KIND_NOP   = 2'd0,
      KIND_TICK  = 2'd1,
      KIND_WRITE = 2'd2,
      KIND_START = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [3:0] entry_index;
      logic [7:0] command_char;
   } item_type;

   typedef struct packed {
      logic [7:0]  base_speed;
      logic [7:0]  left_speed_trim;
      logic [7:0]  right_speed_trim;
      logic [15:0] walk_ticks;
      logic [15:0] turn_ticks;
   } cfg_type;

   typedef struct packed {
      logic [15:0] remaining_ticks;
      logic        running;
      logic        busy_res;
      logic [7:0]  right_speed;
      logic [7:0]  left_speed;
      logic [1:0]  right_drive;
      logic [1:0]  left_drive;
   } rsp_type;

endpackage

// ===== hw/rtl/tmcs_front.sv =====
// front end: takes requests and classifies them into queue items
// depends on tmcs_pkg

module tmcs_front
   import tmcs_pkg::*;
#(
   parameter int PROG_DEPTH = 16
) (
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // entry_index[3:0], command_char[11:4]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        push_valid,
   input  logic        push_ready,
   output item_type    push_item
);

   localparam logic [8:0] DEPTH_L = 9'(PROG_DEPTH);

   logic [3:0] entry_index;
   logic [7:0] command_char;
   logic       in_range;
   kind_type   kind;

   assign entry_index  = req_tdata[3:0];
   assign command_char = req_tdata[11:4];
   assign in_range     = {5'b0, entry_index} < DEPTH_L;

   always_comb begin
      case (req_tuser)
         OP_TICK:  kind = KIND_TICK;
         OP_WRITE: kind = in_range ? KIND_WRITE : KIND_NOP;
         OP_START: kind = KIND_START;
         default:  kind = KIND_NOP;
      endcase
   end

   assign push_valid             = req_tvalid;
   assign req_tready             = push_ready;
   assign push_item.kind         = kind;
   assign push_item.entry_index  = entry_index;
   assign push_item.command_char = command_char;

endmodule

// ===== hw/rtl/tmcs_queue.sv =====
// two-entry queue between front and back end
// depends on tmcs_pkg

module tmcs_queue
   import tmcs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hw/rtl/tmcs_back.sv =====
// back end: program store, sequencer state, countdown and result register
// depends on tmcs_pkg

module tmcs_back
   import tmcs_pkg::*;
#(
   parameter int PROG_DEPTH = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     pop_valid,
   output logic     pop_ready,
   input  item_type pop_item,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   // entries past the writable span always read as zero, so only these are stored
   localparam int STORE_DEPTH = (PROG_DEPTH < ENTRY_SPAN) ? PROG_DEPTH : ENTRY_SPAN;
   localparam int SIW         = $clog2(STORE_DEPTH);
   localparam int PTR_W       = $clog2(PROG_DEPTH + 1);
   localparam logic [PTR_W-1:0] STORE_END = PTR_W'(STORE_DEPTH);
   localparam logic [PTR_W-1:0] PROG_END  = PTR_W'(PROG_DEPTH);

   logic [7:0]       store_ff [STORE_DEPTH];
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic             active_ff, active_in;
   logic             busy_ff, busy_in;
   logic [15:0]      tl_ff, tl_in;
   logic [1:0]       ld_ff, ld_in;
   logic [1:0]       rd_ff, rd_in;
   logic             out_valid_ff;
   rsp_type          out_ff;

   logic             exec;
   logic             store_we;
   logic [7:0]       fetch_char;
   logic [7:0]       left_speed, right_speed;

   function automatic logic [7:0] sat_speed(input logic [7:0] base, input logic [7:0] trim);
      logic [9:0] sum;
      sum = {2'b00, base} + {{2{trim[7]}}, trim};
      if (sum[9]) begin
         return 8'd0;
      end else if (sum[8]) begin
         return 8'hFF;
      end
      return sum[7:0];
   endfunction

   assign pop_ready   = !out_valid_ff || rsp_ready;
   assign exec        = pop_valid && pop_ready;
   assign store_we    = exec && (pop_item.kind == KIND_WRITE);
   assign fetch_char  = (ptr_ff < STORE_END) ? store_ff[ptr_ff[SIW-1:0]] : 8'd0;
   assign left_speed  = sat_speed(cfg.base_speed, cfg.left_speed_trim);
   assign right_speed = sat_speed(cfg.base_speed, cfg.right_speed_trim);

   always_comb begin
      ptr_in    = ptr_ff;
      active_in = active_ff;
      busy_in   = busy_ff;
      tl_in     = tl_ff;
      ld_in     = ld_ff;
      rd_in     = rd_ff;
      case (pop_item.kind)
         KIND_TICK: begin
            if (active_ff && !busy_ff) begin
               if (ptr_ff >= PROG_END || fetch_char == 8'd0) begin
                  active_in = 1'b0;
                  ptr_in    = '0;
               end else begin
                  case (fetch_char)
                     CHAR_F: begin
                        ld_in = DIR_FWD;
                        rd_in = DIR_FWD;
                        tl_in = cfg.walk_ticks;
                     end
                     CHAR_B: begin
                        ld_in = DIR_BWD;
                        rd_in = DIR_BWD;
                        tl_in = cfg.walk_ticks;
                     end
                     CHAR_L: begin
                        ld_in = DIR_BWD;
                        rd_in = DIR_FWD;
                        tl_in = cfg.turn_ticks;
                     end
                     CHAR_R: begin
                        ld_in = DIR_FWD;
                        rd_in = DIR_BWD;
                        tl_in = cfg.turn_ticks;
                     end
                     CHAR_S: begin
                        ld_in = DIR_STOP;
                        rd_in = DIR_STOP;
                     end
                     default: begin
                     end
                  endcase
                  ptr_in = ptr_ff + PTR_W'(1);
               end
            end
            // countdown runs on the value left by the fetch
            if (tl_in != 16'd0) begin
               busy_in = 1'b1;
               tl_in   = tl_in - 16'd1;
            end else begin
               busy_in = 1'b0;
               ld_in   = DIR_STOP;
               rd_in   = DIR_STOP;
            end
         end
         KIND_START: begin
            active_in = 1'b1;
            ptr_in    = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         active_ff    <= 1'b0;
         busy_ff      <= 1'b0;
         tl_ff        <= 16'd0;
         ld_ff        <= DIR_STOP;
         rd_ff        <= DIR_STOP;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < STORE_DEPTH; i++) begin
            store_ff[i] <= 8'd0;
         end
      end else begin
         if (exec) begin
            ptr_ff    <= ptr_in;
            active_ff <= active_in;
            busy_ff   <= busy_in;
            tl_ff     <= tl_in;
            ld_ff     <= ld_in;
            rd_ff     <= rd_in;
         end
         if (store_we) begin
            store_ff[pop_item.entry_index[SIW-1:0]] <= pop_item.command_char;
         end
         if (exec) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         out_ff.left_drive      <= ld_in;
         out_ff.right_drive     <= rd_in;
         out_ff.left_speed      <= left_speed;
         out_ff.right_speed     <= right_speed;
         out_ff.busy_res        <= busy_in;
         out_ff.running         <= active_in;
         out_ff.remaining_ticks <= tl_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== hw/rtl/timed_motion_command_sequencer.sv =====
// top level of the timed motion command sequencer: configuration registers,
// front end, queue and back end; depends on tmcs_pkg and the tmcs_* modules
//
// Each request (tick, program write, start or the unused op) produces one
// response with the drive directions, saturated speeds, busy and running
// flags and remaining ticks after that request. One request is taken every
// clock cycle unless the response side applies back-pressure and the
// two-entry queue fills; requests go through the queue, responses out of the
// back end's response register. The program store sits in flip-flops that
// reset clears at once, so requests are taken as soon as reset is released.
// The user must write configuration through the csr_ port only while no
// response is outstanding; the block itself does not enforce this.

module timed_motion_command_sequencer
   import tmcs_pkg::*;
#(
   parameter int PROG_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // entry_index[3:0], command_char[11:4]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // left_drive[1:0], right_drive[3:2], left_speed[11:4], right_speed[19:12],
   // busy_res[20], running[21], remaining_ticks[37:22]
   output logic [39:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type  cfg_ff;
   logic     push_valid, push_ready;
   item_type push_item;
   logic     pop_valid, pop_ready;
   item_type pop_item;
   rsp_type  rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_speed       <= 8'd128;
         cfg_ff.left_speed_trim  <= 8'd0;
         cfg_ff.right_speed_trim <= 8'd0;
         cfg_ff.walk_ticks       <= 16'd500;
         cfg_ff.turn_ticks       <= 16'd300;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BASE_SPEED: cfg_ff.base_speed       <= csr_wdata[7:0];
            CSR_LEFT_TRIM:  cfg_ff.left_speed_trim  <= csr_wdata[7:0];
            CSR_RIGHT_TRIM: cfg_ff.right_speed_trim <= csr_wdata[7:0];
            CSR_WALK_TICKS: cfg_ff.walk_ticks       <= csr_wdata;
            CSR_TURN_TICKS: cfg_ff.turn_ticks       <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   tmcs_front #(
      .PROG_DEPTH (PROG_DEPTH)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   tmcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   tmcs_back #(
      .PROG_DEPTH (PROG_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data)
   );

   assign rsp_tdata = {2'b00, rsp_data};

endmodule

// ===== tb/timed_motion_command_sequencer_tb.sv =====
// self-checking testbench for the timed motion command sequencer
// drives program writes, starts and ticks, and predicts every response in a scoreboard class
// depends on tmcs_pkg and timed_motion_command_sequencer

module timed_motion_command_sequencer_tb
   import tmcs_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PROG_DEPTH = ENTRY_SPAN;
   localparam logic [1:0] OP_NONE = 2'd3;   // unused op, reports the state unchanged
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 130;
   localparam int HOLD_CYCLES = 60;
   localparam int SETTLE_CYCLES = 4;
   localparam int STALL_LIMIT = 1000;

   class drive_state_scoreboard;
      logic [7:0]  base_speed;
      logic [7:0]  left_trim;
      logic [7:0]  right_trim;
      logic [15:0] walk_ticks;
      logic [15:0] turn_ticks;
      logic [7:0]  program_store [ENTRY_SPAN];
      int          pointer;
      bit          active;
      bit          busy;
      logic [15:0] time_left;
      logic [1:0]  left_dir;
      logic [1:0]  right_dir;
      rsp_type     expected_states [$];
      int          errors;

      function new();
         base_speed = 8'd128;
         left_trim  = 8'd0;
         right_trim = 8'd0;
         walk_ticks = 16'd500;
         turn_ticks = 16'd300;
         foreach (program_store[i]) program_store[i] = 8'd0;
         pointer   = 0;
         active    = 0;
         busy      = 0;
         time_left = 16'd0;
         left_dir  = DIR_STOP;
         right_dir = DIR_STOP;
         errors    = 0;
      endfunction

      function void load_register(logic [2:0] index, logic [15:0] value);
         case (index)
            CSR_BASE_SPEED: base_speed = value[7:0];
            CSR_LEFT_TRIM:  left_trim  = value[7:0];
            CSR_RIGHT_TRIM: right_trim = value[7:0];
            CSR_WALK_TICKS: walk_ticks = value;
            CSR_TURN_TICKS: turn_ticks = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_states.size();
      endfunction

      function logic [7:0] trimmed_speed(logic [7:0] trim);
         int b;
         int t;
         int s;
         b = base_speed;
         t = $signed(trim);
         s = b + t;
         if (s < 0) s = 0;
         if (s > 255) s = 255;
         return 8'(s);
      endfunction

      function void set_motion(logic [1:0] l, logic [1:0] r, logic [15:0] ticks);
         left_dir  = l;
         right_dir = r;
         time_left = ticks;
      endfunction

      function void fetch_next();
         logic [7:0] c;
         // program ends at a zero entry or past the last entry
         if (pointer >= ENTRY_SPAN) begin
            active  = 0;
            pointer = 0;
            return;
         end
         c = program_store[pointer];
         if (c == 8'd0) begin
            active  = 0;
            pointer = 0;
            return;
         end
         case (c)
            CHAR_F: set_motion(DIR_FWD, DIR_FWD, walk_ticks);
            CHAR_B: set_motion(DIR_BWD, DIR_BWD, walk_ticks);
            CHAR_L: set_motion(DIR_BWD, DIR_FWD, turn_ticks);
            CHAR_R: set_motion(DIR_FWD, DIR_BWD, turn_ticks);
            CHAR_S: begin
               left_dir  = DIR_STOP;
               right_dir = DIR_STOP;
            end
            default: ;
         endcase
         pointer++;
      endfunction

      function void predict_drive_state(logic [1:0] op, logic [3:0] idx, logic [7:0] ch);
         rsp_type r;
         case (op)
            OP_TICK: begin
               if (active && !busy) fetch_next();
               if (time_left > 0) begin
                  busy = 1;
                  time_left--;
               end else begin
                  busy      = 0;
                  left_dir  = DIR_STOP;
                  right_dir = DIR_STOP;
               end
            end
            OP_WRITE: program_store[idx] = ch;
            OP_START: begin
               active  = 1;
               pointer = 0;
            end
            default: ;
         endcase
         r.left_drive      = left_dir;
         r.right_drive     = right_dir;
         r.left_speed      = trimmed_speed(left_trim);
         r.right_speed     = trimmed_speed(right_trim);
         r.busy_res        = busy;
         r.running         = active;
         r.remaining_ticks = time_left;
         expected_states.push_back(r);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_drive_state(logic [39:0] data);
         rsp_type got;
         rsp_type want;
         got = data[37:0];
         if (expected_states.size() == 0) begin
            $display("%0t: response with no request outstanding, expected none, actual %h",
                     $time, data);
            errors++;
            return;
         end
         want = expected_states.pop_front();
         compare_field("left_drive", want.left_drive, got.left_drive);
         compare_field("right_drive", want.right_drive, got.right_drive);
         compare_field("left_speed", want.left_speed, got.left_speed);
         compare_field("right_speed", want.right_speed, got.right_speed);
         compare_field("busy_res", want.busy_res, got.busy_res);
         compare_field("running", want.running, got.running);
         compare_field("remaining_ticks", want.remaining_ticks, got.remaining_ticks);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = 16'd0;   // entry_index[3:0], command_char[11:4]
   logic [1:0]  req_tuser = 2'd0;    // op[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // left_drive[1:0], right_drive[3:2], left_speed[11:4], right_speed[19:12],
   // busy_res[20], running[21], remaining_ticks[37:22]
   logic [39:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = 3'd0;
   logic [15:0] csr_wdata = 16'd0;

   drive_state_scoreboard sb;
   int request_count = 0;
   int stalled_cycles = 0;
   bit calm = 0;
   bit hold_pending = 0;

   timed_motion_command_sequencer #(
      .PROG_DEPTH(PROG_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // both handshakes are observed at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.predict_drive_state(req_tuser, req_tdata[3:0], req_tdata[11:4]);
         if (rsp_tvalid && rsp_tready)
            sb.check_drive_state(rsp_tdata);
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stalled_cycles = 0;
      else
         stalled_cycles++;
   end

   initial begin
      wait (stalled_cycles >= STALL_LIMIT);
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("status: fail");
      $finish;
   end

   // response side: random back-pressure, long hold-off on demand
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_tready = 1'b0;
         end else if (hold_pending) begin
            hold_pending = 0;
            hold_left = HOLD_CYCLES;
            rsp_tready = 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
         end else begin
            rsp_tready = calm || ($urandom_range(0, 99) >= 14);
         end
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(input logic [1:0] op, input logic [3:0] idx,
                               input logic [7:0] ch);
      if (!calm) begin
         while ($urandom_range(0, 99) < 14) begin
            req_tvalid = 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {4'd0, ch, idx};
      do @(posedge clock); while (!req_tready);
      request_count++;
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_tvalid = 1'b0;
      while (sb.pending() > 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_register(input logic [2:0] index, input logic [15:0] value);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      sb.load_register(index, value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic logic [7:0] pick_letter();
      int r;
      r = $urandom_range(0, 15);
      if (r < 13) begin
         case ($urandom_range(0, 4))
            0: return CHAR_F;
            1: return CHAR_B;
            2: return CHAR_L;
            3: return CHAR_R;
            default: return CHAR_S;
         endcase
      end
      if (r < 15) return 8'($urandom);
      return 8'd0;
   endfunction

   // fill part or all of the store, start it and tick through it with the odd stray request
   task automatic run_program();
      int len;
      int n;
      len = $urandom_range(1, PROG_DEPTH);
      for (int i = 0; i < len; i++)
         send_request(OP_WRITE, 4'(i), pick_letter());
      if (len < PROG_DEPTH && $urandom_range(0, 9) < 7)
         send_request(OP_WRITE, 4'(len), 8'd0);
      send_request(OP_START, 4'($urandom), 8'($urandom));
      n = $urandom_range(10, 60);
      repeat (n) begin
         if ($urandom_range(0, 99) < 8) begin
            case ($urandom_range(0, 2))
               0: send_request(OP_NONE, 4'($urandom), 8'($urandom));
               1: send_request(OP_WRITE, 4'($urandom), pick_letter());
               default: send_request(OP_START, 4'($urandom), 8'($urandom));
            endcase
         end else begin
            send_request(OP_TICK, 4'($urandom), 8'($urandom));
         end
      end
   endtask

   task automatic configure_phase(input int p);
      logic [7:0]  base;
      logic [7:0]  ltrim;
      logic [7:0]  rtrim;
      logic [15:0] walk;
      logic [15:0] turn;
      base  = 8'($urandom);
      ltrim = 8'($urandom);
      rtrim = 8'($urandom);
      walk  = 16'($urandom_range(0, 6));
      turn  = 16'($urandom_range(0, 6));
      case (p)
         1: begin
            base = 8'd0; ltrim = 8'h80; rtrim = 8'h7F; walk = 16'd0; turn = 16'd0;
         end
         2: begin
            base = 8'hFF; ltrim = 8'h7F; rtrim = 8'h80; walk = 16'd1; turn = 16'd3;
         end
         // longest durations last, a countdown from there never ends within the run
         PHASES - 1: begin
            walk = 16'hFFFF; turn = 16'hFFFF;
         end
         default: ;
      endcase
      set_register(CSR_BASE_SPEED, {8'd0, base});
      set_register(CSR_LEFT_TRIM, {8'd0, ltrim});
      set_register(CSR_RIGHT_TRIM, {8'd0, rtrim});
      set_register(CSR_WALK_TICKS, walk);
      set_register(CSR_TURN_TICKS, turn);
   endtask

   initial begin
      int phase_start;
      int choice;
      int n;
      sb = new();
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // left speed saturates high, right speed is trimmed down, short durations
      set_register(CSR_BASE_SPEED, 16'h00FF);
      set_register(CSR_LEFT_TRIM, 16'h007F);
      set_register(CSR_RIGHT_TRIM, 16'h0080);
      set_register(CSR_WALK_TICKS, 16'd2);
      set_register(CSR_TURN_TICKS, 16'd1);

      // tick while idle, then a program with every letter, an unknown one and a terminator
      send_request(OP_TICK, 4'd0, 8'd0);
      send_request(OP_WRITE, 4'd0, CHAR_F);
      send_request(OP_WRITE, 4'd1, CHAR_B);
      send_request(OP_WRITE, 4'd2, CHAR_L);
      send_request(OP_WRITE, 4'd3, CHAR_R);
      send_request(OP_WRITE, 4'd4, 8'hFF);
      send_request(OP_WRITE, 4'd5, CHAR_S);
      send_request(OP_WRITE, 4'd6, 8'd0);
      send_request(OP_WRITE, 4'hF, CHAR_F);
      send_request(OP_NONE, 4'hF, 8'hFF);
      send_request(OP_START, 4'd0, 8'd0);
      repeat (13) send_request(OP_TICK, 4'd0, 8'd0);

      for (int p = 0; p < PHASES; p++) begin
         wait_for_drain();
         configure_phase(p);
         calm = (p == 6);
         if (p == 3) hold_pending = 1;
         phase_start = request_count;
         while (request_count - phase_start < PHASE_ITEMS) begin
            choice = $urandom_range(0, 99);
            if (choice < 3) begin
               wait_for_drain();
            end else if (choice < 78) begin
               run_program();
            end else begin
               n = $urandom_range(1, 5);
               repeat (n) send_request(2'($urandom), 4'($urandom), 8'($urandom));
            end
         end
      end
      calm = 0;

      wait_for_drain();
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
